>>> hw/rtl/lss_pkg.sv
// shared types, codes and constants of the linear sieve block
`default_nettype none

package lss_pkg;

   // defaults of the top level parameters
   localparam int unsigned MAX_N_DEFAULT      = 65535;
   localparam int unsigned MAX_PRIMES_DEFAULT = 8192;

   // reset value of the limit register, first candidate, count field ceiling
   localparam int unsigned LIMIT_RESET = 65535;
   localparam int unsigned FIRST_PRIME = 2;
   localparam int unsigned COUNT_MAX   = 8191;

   typedef enum logic {
      OP_BUILD = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOT_BUILT   = 2'd1,
      ST_ABOVE_LIMIT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_CHECK,
      S_K_START,
      S_K_MUL,
      S_K_TEST,
      S_FINISH,
      S_QUERY,
      S_RESULT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_req;
      logic start_build;
      logic clr_step;
      logic init_i;
      logic rd_i;
      logic check_i;
      logic rd_prime;
      logic mul;
      logic mark;
      logic k_inc;
      logic i_inc;
      logic finish_build;
      logic rd_query;
      logic load_out;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_build;
      logic lim_small;
      logic clr_last;
      logic i_last;
      logic k_end;
      logic prod_over;
      logic p_is_spf;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/lss_if.sv
// request, response and configuration channel interfaces
`default_nettype none

interface lss_req_if;
   logic                valid;
   logic                ready;
   lss_pkg::opcode_type opcode;
   logic [15:0]         query_index;

   modport source (output valid, output opcode, output query_index, input ready);
   modport sink   (input valid, input opcode, input query_index, output ready);
endinterface

interface lss_rsp_if;
   logic                valid;
   logic                ready;
   logic [15:0]         factor_out;
   logic                prime_flag;
   logic [12:0]         count_out;
   lss_pkg::status_type status;

   modport source (output valid, output factor_out, output prime_flag, output count_out,
                   output status, input ready);
   modport sink   (input valid, input factor_out, input prime_flag, input count_out,
                   input status, output ready);
endinterface

interface lss_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] sieve_limit;

   modport source (output valid, output sieve_limit, input ready);
   modport sink   (input valid, input sieve_limit, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lss_ctrl.sv
// sequencing state machine of the linear sieve block
`default_nettype none

module lss_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lss_pkg::dp_status_type stat,
   output lss_pkg::cmd_type           cmd
);
   import lss_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (stat.req_build) begin
                  cmd.start_build = 1'b1;
                  state_in        = S_CLEAR;
               end else begin
                  state_in = S_QUERY;
               end
            end
         end
         // clearing pass over the covered part of the table
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.init_i = 1'b1;
               state_in   = stat.lim_small ? S_FINISH : S_READ;
            end
         end
         S_READ: begin
            cmd.rd_i = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check_i = 1'b1;
            state_in    = S_K_START;
         end
         // walk over the prime list for the current i
         S_K_START: begin
            if (stat.k_end) begin
               if (stat.i_last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.i_inc = 1'b1;
                  state_in  = S_READ;
               end
            end else begin
               cmd.rd_prime = 1'b1;
               state_in     = S_K_MUL;
            end
         end
         S_K_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_K_TEST;
         end
         S_K_TEST: begin
            if (stat.prod_over || stat.p_is_spf) begin
               cmd.mark = !stat.prod_over;
               if (stat.i_last) begin
                  state_in = S_FINISH;
               end else begin
                  cmd.i_inc = 1'b1;
                  state_in  = S_READ;
               end
            end else begin
               cmd.mark  = 1'b1;
               cmd.k_inc = 1'b1;
               state_in  = S_K_START;
            end
         end
         S_FINISH: begin
            cmd.finish_build = 1'b1;
            state_in         = S_RESULT;
         end
         S_QUERY: begin
            cmd.rd_query = 1'b1;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/lss_dp.sv
// datapath: factor table, prime list, counters, multiplier and result register
`default_nettype none

module lss_dp #(
   parameter int unsigned MAX_N      = lss_pkg::MAX_N_DEFAULT,
   parameter int unsigned MAX_PRIMES = lss_pkg::MAX_PRIMES_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lss_pkg::cmd_type     cmd,
   output lss_pkg::dp_status_type    stat,
   input  wire lss_pkg::opcode_type  req_opcode,
   input  wire logic [15:0]          req_query_index,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [15:0]          csr_sieve_limit,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [15:0]               rsp_factor_out,
   output logic                      rsp_prime_flag,
   output logic [12:0]               rsp_count_out,
   output lss_pkg::status_type       rsp_status
);
   import lss_pkg::*;

   localparam int unsigned NW  = $clog2(MAX_N + 1);
   localparam int unsigned CW  = (NW > 16) ? NW : 16;
   localparam int unsigned PW  = $clog2(MAX_PRIMES + 1);
   localparam int unsigned KW  = $clog2(MAX_PRIMES);
   localparam int unsigned PRW = 2 * NW;

   localparam logic [CW-1:0] MAX_N_C   = CW'(MAX_N);
   localparam logic [PW-1:0] PRIME_CAP = PW'(MAX_PRIMES);
   localparam logic [NW-1:0] FIRST_I   = NW'(FIRST_PRIME);

   // storage
   logic [NW-1:0] sf_mem [0:MAX_N];
   logic [NW-1:0] pl_mem [0:MAX_PRIMES-1];

   logic [15:0]   sieve_limit_ff;
   opcode_type    op_ff;
   logic [15:0]   idx_ff;
   logic [NW-1:0] lim_ff, lim_in;
   logic [NW-1:0] built_lim_ff, built_lim_in;
   logic          ready_ff, ready_in;
   logic [PW-1:0] count_ff, count_in;
   logic [NW-1:0] clr_ff, clr_in;
   logic [NW-1:0] i_ff, i_in;
   logic [PW-1:0] k_ff, k_in;
   logic [NW-1:0] spf_ff, spf_in;
   logic [NW-1:0] p_ff, p_in;
   logic [PRW-1:0] prod_ff, prod_in;
   logic [NW-1:0] sf_rd_ff;
   logic [NW-1:0] pl_rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   factor_ff, factor_in;
   logic          flag_ff, flag_in;
   logic [12:0]   count_out_ff, count_out_in;
   status_type    status_ff, status_in;

   logic [CW-1:0] lim_ext;
   logic [NW-1:0] lim_sel;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] factor_ext;
   logic [12:0]   count_field;
   logic          sf_empty;

   logic          sf_we, sf_re;
   logic [NW-1:0] sf_waddr, sf_wdata, sf_raddr;
   logic          pl_we;

   // limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sieve_limit_ff <= 16'(LIMIT_RESET);
      end else if (csr_valid) begin
         sieve_limit_ff <= csr_sieve_limit;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         idx_ff <= req_query_index;
      end
   end

   // effective limit, clipped to the table size
   assign lim_ext  = (CW'(sieve_limit_ff) > MAX_N_C) ? MAX_N_C : CW'(sieve_limit_ff);
   assign lim_sel  = lim_ext[NW-1:0];
   assign idx_ext  = CW'(idx_ff);
   assign sf_empty = (sf_rd_ff == '0);

   // counters and sieve registers
   always_comb begin
      lim_in       = lim_ff;
      built_lim_in = built_lim_ff;
      ready_in     = ready_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      spf_in       = spf_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      if (cmd.start_build) begin
         lim_in   = lim_sel;
         clr_in   = '0;
         count_in = '0;
         ready_in = 1'b0;
      end
      if (cmd.clr_step) begin
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.init_i) begin
         i_in = FIRST_I;
      end
      if (cmd.i_inc) begin
         i_in = i_ff + 1'b1;
      end
      if (cmd.check_i) begin
         k_in   = '0;
         spf_in = sf_empty ? i_ff : sf_rd_ff;
         if (sf_empty && (count_ff != PRIME_CAP)) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.k_inc) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.mul) begin
         p_in    = pl_rd_ff;
         prod_in = PRW'(i_ff) * PRW'(pl_rd_ff);
      end
      if (cmd.finish_build) begin
         ready_in     = 1'b1;
         built_lim_in = lim_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff     <= 1'b0;
         built_lim_ff <= '0;
         count_ff     <= '0;
      end else begin
         ready_ff     <= ready_in;
         built_lim_ff <= built_lim_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff  <= lim_in;
      clr_ff  <= clr_in;
      i_ff    <= i_in;
      k_ff    <= k_in;
      spf_ff  <= spf_in;
      p_ff    <= p_in;
      prod_ff <= prod_in;
   end

   // factor table ports
   always_comb begin
      sf_we    = 1'b0;
      sf_waddr = clr_ff;
      sf_wdata = '0;
      if (cmd.clr_step) begin
         sf_we = 1'b1;
      end else if (cmd.check_i && sf_empty) begin
         sf_we    = 1'b1;
         sf_waddr = i_ff;
         sf_wdata = i_ff;
      end else if (cmd.mark) begin
         sf_we    = 1'b1;
         sf_waddr = prod_ff[NW-1:0];
         sf_wdata = p_ff;
      end
   end

   assign sf_re    = cmd.rd_i || cmd.rd_query;
   assign sf_raddr = cmd.rd_i ? i_ff : idx_ext[NW-1:0];

   always_ff @(posedge clock) begin
      if (sf_we) begin
         sf_mem[sf_waddr] <= sf_wdata;
      end
      if (sf_re) begin
         sf_rd_ff <= sf_mem[sf_raddr];
      end
   end

   // prime list ports
   assign pl_we = cmd.check_i && sf_empty && (count_ff != PRIME_CAP);

   always_ff @(posedge clock) begin
      if (pl_we) begin
         pl_mem[count_ff[KW-1:0]] <= i_ff;
      end
      if (cmd.rd_prime) begin
         pl_rd_ff <= pl_mem[k_ff[KW-1:0]];
      end
   end

   // status to the controller
   always_comb begin
      stat.req_build = (req_opcode == OP_BUILD);
      stat.lim_small = (lim_ff < FIRST_I);
      stat.clr_last  = (clr_ff == lim_ff);
      stat.i_last    = (i_ff == lim_ff);
      stat.k_end     = (k_ff == count_ff);
      stat.prod_over = (prod_ff > PRW'(lim_ff));
      stat.p_is_spf  = (p_ff == spf_ff);
      stat.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // result word
   assign factor_ext  = CW'(sf_rd_ff);
   assign count_field = (32'(count_ff) > COUNT_MAX) ? 13'(COUNT_MAX) : 13'(count_ff);

   always_comb begin
      factor_in    = factor_ff;
      flag_in      = flag_ff;
      count_out_in = count_out_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         factor_in    = '0;
         flag_in      = 1'b0;
         count_out_in = count_field;
         status_in    = ST_OK;
         if (op_ff == OP_QUERY) begin
            if (!ready_ff) begin
               status_in = ST_NOT_BUILT;
            end else if (idx_ext > CW'(built_lim_ff)) begin
               status_in = ST_ABOVE_LIMIT;
            end else if (idx_ff >= 16'(FIRST_PRIME)) begin
               factor_in = factor_ext[15:0];
               flag_in   = (factor_ext == idx_ext);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      factor_ff    <= factor_in;
      flag_ff      <= flag_in;
      count_out_ff <= count_out_in;
      status_ff    <= status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_factor_out = factor_ff;
   assign rsp_prime_flag = flag_ff;
   assign rsp_count_out  = count_out_ff;
   assign rsp_status     = status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/linear_sieve_smallest_factor.sv
// Linear sieve with smallest-prime-factor table, one word at a time.
// Query: the accepted word reads the table in S_QUERY, and S_RESULT loads the result register
// once the output is free; the next word is taken back in S_IDLE. Build: a clearing pass, then
// per i a table read and check, per listed prime tried a read, multiply and test, then S_FINISH.
// Reset (synchronous, active high): table not built, count zero, limit 65535.
// The factor table has no reset; each build clears entries 0 to limit first.
`default_nettype none

module linear_sieve_smallest_factor #(
   parameter int unsigned MAX_N      = lss_pkg::MAX_N_DEFAULT,
   parameter int unsigned MAX_PRIMES = lss_pkg::MAX_PRIMES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   lss_req_if.sink   req_bus,
   lss_rsp_if.source rsp_bus,
   lss_csr_if.sink   csr_bus
);
   import lss_pkg::*;

   cmd_type       cmd;
   dp_status_type stat;
   logic          req_ready;
   logic          csr_ready;
   logic          rsp_valid;
   logic [15:0]   rsp_factor_out;
   logic          rsp_prime_flag;
   logic [12:0]   rsp_count_out;
   status_type    rsp_status;

   // controller
   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   lss_dp #(
      .MAX_N      (MAX_N),
      .MAX_PRIMES (MAX_PRIMES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_bus.opcode),
      .req_query_index (req_bus.query_index),
      .csr_valid       (csr_bus.valid),
      .csr_ready       (csr_ready),
      .csr_sieve_limit (csr_bus.sieve_limit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_factor_out  (rsp_factor_out),
      .rsp_prime_flag  (rsp_prime_flag),
      .rsp_count_out   (rsp_count_out),
      .rsp_status      (rsp_status)
   );

   // channel hookup
   assign req_bus.ready      = req_ready;
   assign csr_bus.ready      = csr_ready;
   assign rsp_bus.valid      = rsp_valid;
   assign rsp_bus.factor_out = rsp_factor_out;
   assign rsp_bus.prime_flag = rsp_prime_flag;
   assign rsp_bus.count_out  = rsp_count_out;
   assign rsp_bus.status     = rsp_status;

endmodule

`default_nettype wire

>>> hw/rtl/lss_checker.sv
// port-level checks of the linear sieve block, bound to the top level
`default_nettype none

module lss_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [15:0]         rsp_factor_out,
   input wire logic                rsp_prime_flag,
   input wire logic [12:0]         rsp_count_out,
   input wire lss_pkg::status_type rsp_status
);
   import lss_pkg::*;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_factor_out)
         && $stable(rsp_prime_flag) && $stable(rsp_count_out) && $stable(rsp_status))
      else $error("stalled result word changed");

   // one word in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is in progress");

   // error status words carry no factor and no prime flag
   a_error_no_factor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_factor_out == 16'd0) && !rsp_prime_flag)
      else $error("factor reported with error status");

   // a prime carries ok status and a factor of at least two
   a_prime_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_prime_flag |-> (rsp_status == ST_OK) && (rsp_factor_out > 16'd1))
      else $error("prime flag with bad status or factor");

endmodule

bind linear_sieve_smallest_factor lss_checker u_lss_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_factor_out (rsp_bus.factor_out),
   .rsp_prime_flag (rsp_bus.prime_flag),
   .rsp_count_out  (rsp_bus.count_out),
   .rsp_status     (rsp_bus.status)
);

`default_nettype wire

>>> tb/sv/tb_linear_sieve_smallest_factor.sv
// testbench for the linear sieve block: builds, queries and a smallest-factor predictor
module tb_linear_sieve_smallest_factor;
   import lss_pkg::*;

   localparam int unsigned SIEVE_TOP   = MAX_N_DEFAULT;
   localparam int unsigned LIST_DEPTH  = MAX_PRIMES_DEFAULT;
   localparam int unsigned WORD_TARGET = 1200;
   localparam int unsigned TAIL_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT = 20000000;
   localparam int unsigned REPORT_CAP  = 50;

   typedef struct {
      logic [15:0] factor;
      logic        flag;
      logic [12:0] count;
      status_type  status;
   } sieve_answer_type;

   logic clock = 1'b0;
   logic reset;

   lss_req_if req ();
   lss_rsp_if rsp ();
   lss_csr_if csr ();

   linear_sieve_smallest_factor i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req),
      .rsp_bus (rsp),
      .csr_bus (csr)
   );

   // clock
   always #1 clock = ~clock;

   // predictor state: own copy of the table, prime list and limit register
   int unsigned   spf_table [0:SIEVE_TOP];
   int unsigned   prime_seq [0:LIST_DEPTH-1];
   int unsigned   n_primes    = 0;
   bit            table_built = 1'b0;
   int unsigned   table_limit = 0;
   logic [15:0]   limit_reg   = 16'(LIMIT_RESET);

   sieve_answer_type answers_due [$];
   int unsigned   words_sent  = 0;
   int unsigned   mismatches  = 0;
   int unsigned   cycle_count = 0;
   int unsigned   hold_left   = 0;
   bit            quiet       = 1'b0;

   // linear sieve over the latched limit, same walk as the block
   function automatic void build_sieve();
      int unsigned     lim;
      int unsigned     i;
      int unsigned     k;
      int unsigned     p;
      longint unsigned prod;
      lim = (limit_reg > SIEVE_TOP) ? SIEVE_TOP : limit_reg;
      for (i = 0; i <= SIEVE_TOP; i++) spf_table[i] = 0;
      n_primes = 0;
      for (i = FIRST_PRIME; i <= lim; i++) begin
         if (spf_table[i] == 0) begin
            spf_table[i] = i;
            // a full list still marks the prime but no longer records it
            if (n_primes < LIST_DEPTH) begin
               prime_seq[n_primes] = i;
               n_primes++;
            end
         end
         for (k = 0; k < n_primes; k++) begin
            p    = prime_seq[k];
            prod = longint'(i) * p;
            if (prod > lim) break;
            spf_table[prod] = p;
            if (p == spf_table[i]) break;
         end
      end
      table_limit = lim;
      table_built = 1'b1;
   endfunction

   // expected result of one accepted word
   function automatic sieve_answer_type predict_answer(opcode_type op, logic [15:0] idx);
      sieve_answer_type a;
      a.factor = '0;
      a.flag   = 1'b0;
      a.status = ST_OK;
      if (op == OP_BUILD) begin
         build_sieve();
      end else if (!table_built) begin
         a.status = ST_NOT_BUILT;
      end else if (idx > table_limit) begin
         a.status = ST_ABOVE_LIMIT;
      end else if (idx >= FIRST_PRIME) begin
         a.factor = spf_table[idx][15:0];
         a.flag   = (spf_table[idx] == idx);
      end
      a.count = 13'((n_primes > COUNT_MAX) ? COUNT_MAX : n_primes);
      return a;
   endfunction

   // mostly no pause, some short, a few long
   function automatic int unsigned pause_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      if (mismatches < REPORT_CAP)
         $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
      mismatches++;
   endtask

   // one request word; valid stays high so back-to-back words need no drop
   task automatic send_word(opcode_type op, logic [15:0] idx);
      int unsigned      gap;
      sieve_answer_type expected;
      gap = quiet ? 0 : pause_length();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.opcode      <= op;
      req.query_index <= idx;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
      expected = predict_answer(op, idx);
      answers_due.insert(answers_due.size(), expected);
      words_sent++;
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // limit register write, only while the block is idle
   task automatic set_limit(logic [15:0] value);
      csr.valid       <= 1'b1;
      csr.sieve_limit <= value;
      @(posedge clock);
      while (csr.ready !== 1'b1) @(posedge clock);
      csr.valid <= 1'b0;
      limit_reg = value;
   endtask

   // result sink with random back-pressure
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         rsp.ready <= 1'b0;
         hold_left <= pause_length();
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // compare each result word with the oldest expectation
   always @(posedge clock) begin : check_words
      sieve_answer_type want;
      if (reset === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result word with nothing due", rsp.factor_out, 0);
         end else begin
            want = answers_due.pop_front();
            if (rsp.factor_out !== want.factor)
               report_mismatch("factor_out", rsp.factor_out, want.factor);
            if (rsp.prime_flag !== want.flag)
               report_mismatch("prime_flag", rsp.prime_flag, want.flag);
            if (rsp.count_out !== want.count)
               report_mismatch("count_out", rsp.count_out, want.count);
            if (rsp.status !== want.status)
               report_mismatch("status", int'(rsp.status), int'(want.status));
         end
      end
   end

   // queries before any build report the table as not built
   task automatic check_unbuilt_queries();
      send_word(OP_QUERY, 16'd5);
      send_word(OP_QUERY, 16'hFFFF);
      settle();
   endtask

   // limits of zero, one and two: empty or single-prime tables
   task automatic check_tiny_limits();
      set_limit(16'd0);
      send_word(OP_BUILD, 16'h0000);
      send_word(OP_QUERY, 16'd0);
      send_word(OP_QUERY, 16'd1);
      send_word(OP_QUERY, 16'd2);
      settle();
      set_limit(16'd1);
      send_word(OP_BUILD, 16'hFFFF);
      send_word(OP_QUERY, 16'd1);
      send_word(OP_QUERY, 16'd2);
      settle();
      set_limit(16'd2);
      send_word(OP_BUILD, 16'h0000);
      send_word(OP_QUERY, 16'd2);
      send_word(OP_QUERY, 16'd3);
      settle();
   endtask

   // widest table, then a limit change that must not touch the built table
   task automatic check_full_table();
      set_limit(16'hFFFF);
      send_word(OP_BUILD, 16'h0000);
      send_word(OP_QUERY, 16'hFFFF);
      send_word(OP_QUERY, 16'd65521);
      send_word(OP_QUERY, 16'h8000);
      send_word(OP_QUERY, 16'hFFFE);
      settle();
      set_limit(16'd100);
      send_word(OP_QUERY, 16'd1000);
      send_word(OP_QUERY, 16'hFFFF);
      settle();
   endtask

   // random phases: new limit, usually a build, then a burst of queries
   task automatic check_random_sieves();
      int unsigned r;
      int unsigned n;
      int unsigned j;
      int unsigned top;
      logic [15:0] lim;
      logic [15:0] idx;
      while (words_sent < WORD_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 5)       lim = 16'($urandom_range(0, 1));
         else if (r < 70) lim = 16'($urandom_range(2, 300));
         else if (r < 95) lim = 16'($urandom_range(301, 2000));
         else             lim = 16'($urandom_range(2001, 5000));
         set_limit(lim);
         // sometimes skip the build so queries run against the old table
         if ($urandom_range(0, 99) < 85) send_word(OP_BUILD, 16'($urandom));
         n = $urandom_range(40, 120);
         for (j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
               send_word(OP_BUILD, 16'($urandom));
            end else begin
               top = table_limit + $urandom_range(1, 3);
               if (r < 62)      idx = 16'($urandom_range(0, table_limit));
               else if (r < 76) idx = 16'($urandom_range(0, 3));
               else if (r < 88) idx = 16'((top > 16'hFFFF) ? 16'hFFFF : top);
               else             idx = 16'($urandom);
               send_word(OP_QUERY, idx);
            end
         end
         settle();
      end
      quiet = 1'b0;
   endtask

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   // reset, tests in turn, verdict
   initial begin
      req.valid       = 1'b0;
      req.opcode      = OP_BUILD;
      req.query_index = '0;
      csr.valid       = 1'b0;
      csr.sieve_limit = '0;
      rsp.ready       = 1'b0;
      reset           = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      check_unbuilt_queries();
      check_tiny_limits();
      check_full_table();
      check_random_sieves();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (answers_due.size() != 0)
         report_mismatch("results never returned", answers_due.size(), 0);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/lss_pkg.sv
hw/rtl/lss_if.sv
hw/rtl/lss_ctrl.sv
hw/rtl/lss_dp.sv
hw/rtl/linear_sieve_smallest_factor.sv
hw/rtl/lss_checker.sv
tb/sv/tb_linear_sieve_smallest_factor.sv
